[design/shd_pkg.sv]
package shd_pkg;

	// Width of one stream word, of the register port and of the result counters.
	localparam int BYTE_BITS  = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int COUNT_W    = 32;

	// Phase codes as seen on the result port.
	localparam logic [1:0] PHASE_HUNT   = 2'd0;
	localparam logic [1:0] PHASE_HEADER = 2'd1;
	localparam logic [1:0] PHASE_BODY   = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_OFFSET = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BYTES  = 8'd3;

	// Register values after reset.
	localparam logic [31:0] RST_SYNC_WORD     = 32'd0;
	localparam logic [4:0]  RST_HEADER_BYTES  = 5'd8;
	localparam logic [3:0]  RST_LENGTH_OFFSET = 4'd4;
	localparam logic [2:0]  RST_LENGTH_BYTES  = 3'd4;

	// The length field is at most four bytes wide.
	localparam logic [2:0] MAX_LENGTH_BYTES = 3'd4;

	typedef struct packed {
		logic [31:0] sync_word;
		logic [4:0]  header_bytes;
		logic [3:0]  length_offset;
		logic [2:0]  length_bytes;
	} shd_cfg_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic               slip;
		logic               packet_done;
		logic [COUNT_W-1:0] body_left;
		logic [COUNT_W-1:0] error_count;
		logic [COUNT_W-1:0] packet_count;
	} shd_result_t;

endpackage

[design/sync_hunt_packet_deframer.sv]
// Sync hunt packet deframer. Takes one stream word (byte) per cycle while
// in_stall is low, hunts for the configured sync pattern, reads the header,
// pulls the little-endian body length from it and skips the body, giving one
// result word per input word. A word is registered on entry, processed by the
// state update and held in an output register; the block sustains one word
// per cycle unless the output stalls. With the output stalled the entry
// register still takes one input word if empty; in_stall rises while it holds
// one. The user must write registers through the cfg port only while no word
// is in flight; the block does not enforce this. cfg_ready is always high.
module sync_hunt_packet_deframer
	import shd_pkg::*;
#(
	parameter int SYNC_BYTES       = 4,
	parameter int MAX_HEADER_BYTES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BYTE_BITS-1:0]  stream_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            phase,
	output logic                  slip,
	output logic                  packet_done,
	output logic [COUNT_W-1:0]    body_left,
	output logic [COUNT_W-1:0]    error_count,
	output logic [COUNT_W-1:0]    packet_count
);

	shd_cfg_t             cfg;
	shd_result_t          core_result;
	shd_result_t          result_s2;
	logic                 valid_s1;
	logic                 valid_s2;
	logic [BYTE_BITS-1:0] byte_s1;
	logic                 step;

	assign cfg_ready = 1'b1;

	shd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The entry word moves on when the output register is empty or draining.
	assign step     = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~step;

	// Entry register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= stream_byte;
		end
	end

	shd_core #(
		.SYNC_BYTES       (SYNC_BYTES),
		.MAX_HEADER_BYTES (MAX_HEADER_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (step),
		.stream_byte (byte_s1),
		.result      (core_result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= core_result;
		end
	end

	assign out_valid    = valid_s2;
	assign phase        = result_s2.phase;
	assign slip         = result_s2.slip;
	assign packet_done  = result_s2.packet_done;
	assign body_left    = result_s2.body_left;
	assign error_count  = result_s2.error_count;
	assign packet_count = result_s2.packet_count;

endmodule

[design/shd_cfg_regs.sv]
module shd_cfg_regs
	import shd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output shd_cfg_t              cfg
);

	shd_cfg_t cfg_q;

	// Register file; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_word     <= RST_SYNC_WORD;
			cfg_q.header_bytes  <= RST_HEADER_BYTES;
			cfg_q.length_offset <= RST_LENGTH_OFFSET;
			cfg_q.length_bytes  <= RST_LENGTH_BYTES;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SYNC_WORD:     cfg_q.sync_word     <= wr_data[31:0];
				CFG_HEADER_BYTES:  cfg_q.header_bytes  <= wr_data[4:0];
				CFG_LENGTH_OFFSET: cfg_q.length_offset <= wr_data[3:0];
				CFG_LENGTH_BYTES:  cfg_q.length_bytes  <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/shd_core.sv]
module shd_core
	import shd_pkg::*;
#(
	parameter int SYNC_BYTES       = 4,
	parameter int MAX_HEADER_BYTES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shd_cfg_t             cfg,
	input  logic                 step,
	input  logic [BYTE_BITS-1:0] stream_byte,
	output shd_result_t          result
);

	localparam int WIN_W   = SYNC_BYTES * BYTE_BITS;
	localparam int FILL_MAX = (MAX_HEADER_BYTES > SYNC_BYTES) ? MAX_HEADER_BYTES : SYNC_BYTES;
	localparam int FILL_W  = $clog2(FILL_MAX + 1);
	localparam int CMP_W   = (FILL_W > 5) ? FILL_W + 1 : 6;

	localparam logic [FILL_W-1:0] FILL_SYNC      = FILL_W'(SYNC_BYTES);
	localparam logic [FILL_W-1:0] FILL_SYNC_LAST = FILL_W'(SYNC_BYTES - 1);
	localparam logic [CMP_W-1:0]  HDR_MIN        = CMP_W'(SYNC_BYTES + 1);
	localparam logic [CMP_W-1:0]  HDR_MAX        = CMP_W'(MAX_HEADER_BYTES);
	localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

	logic [1:0]         phase_q;
	logic [WIN_W-1:0]   window_q;
	logic [FILL_W-1:0]  fill_q;
	logic [31:0]        accum_q;
	logic [COUNT_W-1:0] skip_q;
	logic [COUNT_W-1:0] err_q;
	logic [COUNT_W-1:0] pkt_q;

	logic [1:0]         phase_n;
	logic [WIN_W-1:0]   window_n;
	logic [FILL_W-1:0]  fill_n;
	logic [31:0]        accum_n;
	logic [COUNT_W-1:0] skip_n;
	logic [COUNT_W-1:0] err_n;
	logic [COUNT_W-1:0] pkt_n;
	logic               slip;
	logic               done;

	logic [WIN_W-1:0]   sync_cmp;
	logic [WIN_W-1:0]   win_ins;
	logic [FILL_W-1:0]  hunt_pos;
	logic [CMP_W-1:0]   hdr_len;
	logic [CMP_W-1:0]   pos_ext;
	logic [CMP_W-1:0]   pos_next;
	logic [CMP_W-1:0]   rel;
	logic [2:0]         len_w;
	logic               in_field;
	logic [31:0]        accum_ins;
	logic [COUNT_W-1:0] skip_dec;

	// Sync pattern at window width; lanes above the register compare to zero.
	for (genvar i = 0; i < WIN_W; i++) begin : g_sync
		if (i < 32) begin : g_bit
			assign sync_cmp[i] = cfg.sync_word[i];
		end else begin : g_zero
			assign sync_cmp[i] = 1'b0;
		end
	end

	// Hunt: drop the new word into the first free lane of the window.
	assign hunt_pos = (fill_q >= FILL_SYNC) ? FILL_SYNC_LAST : fill_q;
	always_comb begin
		win_ins = window_q;
		for (int k = 0; k < SYNC_BYTES; k++) begin
			if (hunt_pos == FILL_W'(k)) begin
				win_ins[k*BYTE_BITS +: BYTE_BITS] = window_q[k*BYTE_BITS +: BYTE_BITS] | stream_byte;
			end
		end
	end

	// Header: effective header length and the length field lane hit.
	always_comb begin
		hdr_len = CMP_W'(cfg.header_bytes);
		if (hdr_len < HDR_MIN) begin
			hdr_len = HDR_MIN;
		end
		if (hdr_len > HDR_MAX) begin
			hdr_len = HDR_MAX;
		end
	end

	assign len_w    = (cfg.length_bytes > MAX_LENGTH_BYTES) ? MAX_LENGTH_BYTES : cfg.length_bytes;
	assign pos_ext  = CMP_W'(fill_q);
	assign pos_next = pos_ext + CMP_W'(1);
	assign rel      = pos_ext - CMP_W'(cfg.length_offset);
	assign in_field = (pos_ext >= CMP_W'(cfg.length_offset)) && (rel < CMP_W'(len_w));

	always_comb begin
		accum_ins = accum_q;
		for (int k = 0; k < 4; k++) begin
			if (in_field && (rel[1:0] == 2'(k))) begin
				accum_ins[k*BYTE_BITS +: BYTE_BITS] = accum_q[k*BYTE_BITS +: BYTE_BITS] | stream_byte;
			end
		end
	end

	assign skip_dec = (skip_q != '0) ? skip_q - COUNT_W'(1) : skip_q;

	// Next state for one stream word.
	always_comb begin
		phase_n  = phase_q;
		window_n = window_q;
		fill_n   = fill_q;
		accum_n  = accum_q;
		skip_n   = skip_q;
		slip     = 1'b0;
		done     = 1'b0;
		case (phase_q)
			PHASE_HEADER: begin
				accum_n = accum_ins;
				fill_n  = FILL_W'(pos_next);
				if (pos_next >= hdr_len) begin
					if (accum_ins == 32'd0) begin
						done     = 1'b1;
						skip_n   = '0;
						phase_n  = PHASE_HUNT;
						window_n = '0;
						fill_n   = '0;
					end else begin
						skip_n  = COUNT_W'(accum_ins);
						phase_n = PHASE_BODY;
					end
				end
			end
			PHASE_BODY: begin
				skip_n = skip_dec;
				if (skip_dec == '0) begin
					done     = 1'b1;
					phase_n  = PHASE_HUNT;
					window_n = '0;
					fill_n   = '0;
				end
			end
			default: begin
				phase_n  = PHASE_HUNT;
				window_n = win_ins;
				fill_n   = hunt_pos + FILL_W'(1);
				if (hunt_pos == FILL_SYNC_LAST) begin
					if (win_ins == sync_cmp) begin
						phase_n = PHASE_HEADER;
						fill_n  = FILL_SYNC;
						accum_n = 32'd0;
					end else begin
						window_n = win_ins >> BYTE_BITS;
						fill_n   = FILL_SYNC_LAST;
						slip     = 1'b1;
					end
				end
			end
		endcase
	end

	// Saturating error and packet totals.
	assign err_n = (slip && (err_q != COUNT_MAX)) ? err_q + COUNT_W'(1) : err_q;
	assign pkt_n = (done && (pkt_q != COUNT_MAX)) ? pkt_q + COUNT_W'(1) : pkt_q;

	// Deframer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_HUNT;
			window_q <= '0;
			fill_q   <= '0;
			accum_q  <= '0;
			skip_q   <= '0;
			err_q    <= '0;
			pkt_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			window_q <= window_n;
			fill_q   <= fill_n;
			accum_q  <= accum_n;
			skip_q   <= skip_n;
			err_q    <= err_n;
			pkt_q    <= pkt_n;
		end
	end

	// Result for the word being stepped.
	assign result.phase        = phase_n;
	assign result.slip         = slip;
	assign result.packet_done  = done;
	assign result.body_left    = (phase_n == PHASE_BODY) ? skip_n : '0;
	assign result.error_count  = err_n;
	assign result.packet_count = pkt_n;

endmodule

[design/shd_checker.sv]
module shd_checker
	import shd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         phase,
	input logic               slip,
	input logic               packet_done,
	input logic [COUNT_W-1:0] body_left
);

	// A word cannot both slip the window and finish a packet.
	a_slip_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(slip && packet_done))
		else $error("slip and packet_done both set");

	// Slips and finished packets both leave the deframer hunting.
	a_back_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (slip || packet_done) |-> phase == PHASE_HUNT)
		else $error("slip or packet end not followed by hunt phase");

	// Body count is live exactly while skipping the body.
	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((phase == PHASE_BODY) == (body_left != '0)))
		else $error("body_left inconsistent with phase");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(phase) && $stable(body_left))
		else $error("stalled result word changed");

endmodule

bind sync_hunt_packet_deframer shd_checker u_shd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.phase       (phase),
	.slip        (slip),
	.packet_done (packet_done),
	.body_left   (body_left)
);
